// ===== hdl/ols_pkg.sv =====
// ols_pkg: shared types and constants for the ordered list shift store.
// Holds mode and status codes, the command word between front and back,
// and the back-end sequencer state type. No dependencies.
package ols_pkg;

   // default sizing, handed down from the top level
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed field widths
   localparam int POS_W    = 6;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // classified operation
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_READ,
      OP_CLEAR
   } op_type;

   // command word from front queue to back end
   typedef struct packed {
      op_type            op;
      logic [POS_W-1:0]  pos;
   } cmd_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      B_IDLE,
      B_INS_SHIFT,
      B_DEL,
      B_READ,
      B_RDATA,
      B_DONE
   } back_state_type;

endpackage

// ===== hdl/ordered_list_shift_store.sv =====
// ordered_list_shift_store: top level of the ordered list with shifting store.
// Depends on ols_pkg, ols_front (intake queue) and ols_back (store, sequencer).
//
//   channel  ports                                         direction
//   req      req_valid/req_stall, mode, position, value    in
//   rsp      rsp_valid/rsp_stall, status, read_value,      out
//            length, removed_count
//
// Each word passes through the intake queue, then the back end: clear, full
// insert or out-of-range read go straight to the response; read steps through
// B_READ and B_RDATA; insert walks down from the tail to the position; delete
// streams the whole list. The store has separate read and write ports.
// Reset is synchronous, clears the length, queue and response valid; the
// store itself is not cleared. The queue keeps accepting while a response
// waits under rsp_stall; req_stall rises only when the two-word queue is full.
module ordered_list_shift_store
   import ols_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int LW        = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [POS_W-1:0]      req_position,
   input  logic [DATA_WIDTH-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_read_value,
   output logic [LW-1:0]         rsp_length,
   output logic [LW-1:0]         rsp_removed_count
);

   logic                  q_valid;
   cmd_type               q_cmd;
   logic [DATA_WIDTH-1:0] q_word;
   logic                  q_pop;

   // intake and classification
   ols_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_value    (req_value),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_word       (q_word),
      .q_pop        (q_pop)
   );

   // store and sequencer
   ols_back #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .q_word            (q_word),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_length        (rsp_length),
      .rsp_removed_count (rsp_removed_count)
   );

endmodule

// ===== hdl/ols_front.sv =====
// ols_front: request intake, mode classification and a two-word command queue.
// Depends on ols_pkg.
module ols_front
   import ols_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [POS_W-1:0]      req_position,
   input  logic [DATA_WIDTH-1:0] req_value,
   output logic                  q_valid,
   output cmd_type               q_cmd,
   output logic [DATA_WIDTH-1:0] q_word,
   input  logic                  q_pop
);

   localparam int QDEPTH = 2;

   cmd_type               cmd_mem [QDEPTH];
   logic [DATA_WIDTH-1:0] word_mem [QDEPTH];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;
   logic                  pop;
   cmd_type               cmd_new;

   // classify the incoming mode
   always_comb begin
      cmd_new.op  = OP_INSERT;
      cmd_new.pos = req_position;
      unique case (req_mode)
         MODE_INSERT: cmd_new.op = OP_INSERT;
         MODE_DELETE: cmd_new.op = OP_DELETE;
         MODE_READ:   cmd_new.op = OP_READ;
         MODE_CLEAR:  cmd_new.op = OP_CLEAR;
      endcase
   end

   // queue control
   assign req_stall = (count_ff == 2'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = cmd_mem[rd_ptr_ff];
   assign q_word    = word_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem[wr_ptr_ff]  <= cmd_new;
         word_mem[wr_ptr_ff] <= req_value;
      end
   end

endmodule

// ===== hdl/ols_back.sv =====
// ols_back: list store memory, operation sequencer and response register.
// Depends on ols_pkg; fed by ols_front's command queue.
module ols_back
   import ols_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int LW        = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  cmd_type               q_cmd,
   input  logic [DATA_WIDTH-1:0] q_word,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_read_value,
   output logic [LW-1:0]         rsp_length,
   output logic [LW-1:0]         rsp_removed_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = (LW > POS_W) ? LW : POS_W;

   // list store
   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   back_state_type        state_ff, state_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [LW-1:0]         ptr_ff, ptr_in;
   logic [LW-1:0]         pos_ff, pos_in;
   logic [LW-1:0]         keep_ff, keep_in;
   logic [LW-1:0]         rem_ff, rem_in;
   logic [AW-1:0]         widx_ff, widx_in;
   logic                  pend_ff, pend_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic [LW-1:0]         rsp_length_ff;
   logic [LW-1:0]         rsp_removed_ff;
   logic                  rsp_load;

   logic [CW-1:0]         pos_ext, len_ext;
   logic                  full, in_range;
   logic [LW-1:0]         pos_cl, ptr_dec;
   logic                  ins_issue, del_issue, out_free;

   // command decode against current length
   assign pos_ext   = CW'(q_cmd.pos);
   assign len_ext   = CW'(len_ff);
   assign full      = (len_ff >= LW'(CAPACITY));
   assign in_range  = (pos_ext < len_ext);
   assign pos_cl    = (pos_ext > len_ext) ? len_ff : pos_ext[LW-1:0];
   assign ptr_dec   = ptr_ff - LW'(1);
   assign ins_issue = (ptr_ff > pos_ff);
   assign del_issue = (ptr_ff < len_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.op)
                  OP_INSERT: state_in = full ? B_DONE : B_INS_SHIFT;
                  OP_DELETE: state_in = B_DEL;
                  OP_READ:   state_in = in_range ? B_READ : B_DONE;
                  OP_CLEAR:  state_in = B_DONE;
               endcase
            end
         end
         B_INS_SHIFT: begin
            if (!ins_issue && !pend_ff) state_in = B_DONE;
         end
         B_DEL: begin
            if (!del_issue && !pend_ff) state_in = B_DONE;
         end
         B_READ:  state_in = B_RDATA;
         B_RDATA: state_in = B_DONE;
         B_DONE: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      len_in    = len_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      keep_in   = keep_ff;
      rem_in    = rem_ff;
      widx_in   = widx_ff;
      pend_in   = pend_ff;
      word_in   = word_ff;
      value_in  = value_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = '0;
      mem_raddr = '0;
      mem_wdata = '0;
      q_pop     = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               word_in   = q_word;
               pos_in    = pos_cl;
               ptr_in    = (q_cmd.op == OP_DELETE) ? '0 : len_ff;
               keep_in   = '0;
               rem_in    = '0;
               pend_in   = 1'b0;
               value_in  = '0;
               status_in = STATUS_OK;
               unique case (q_cmd.op)
                  OP_INSERT: if (full) status_in = STATUS_FULL;
                  OP_DELETE: ;
                  OP_READ:   if (!in_range) status_in = STATUS_RANGE;
                  OP_CLEAR:  len_in = '0;
               endcase
            end
         end
         B_INS_SHIFT: begin
            // walk down from the tail, moving each word up one place
            pend_in = 1'b0;
            if (ins_issue) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_dec[AW-1:0];
               widx_in   = ptr_ff[AW-1:0];
               ptr_in    = ptr_dec;
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = widx_ff;
               mem_wdata = rd_data_ff;
            end
            if (!ins_issue && !pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[AW-1:0];
               mem_wdata = word_ff;
               len_in    = len_ff + LW'(1);
            end
         end
         B_DEL: begin
            // stream every word through, write back the survivors packed
            pend_in = 1'b0;
            if (del_issue) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff + LW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               if (rd_data_ff == word_ff) begin
                  rem_in = rem_ff + LW'(1);
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = keep_ff[AW-1:0];
                  mem_wdata = rd_data_ff;
                  keep_in   = keep_ff + LW'(1);
               end
            end
            if (!del_issue && !pend_ff) len_in = keep_ff;
         end
         B_READ: begin
            mem_re    = 1'b1;
            mem_raddr = pos_ff[AW-1:0];
         end
         B_RDATA: value_in = rd_data_ff;
         B_DONE: begin
            if (out_free) rsp_load = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pend_ff  <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      pos_ff    <= pos_in;
      keep_ff   <= keep_in;
      rem_ff    <= rem_in;
      widx_ff   <= widx_in;
      word_ff   <= word_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_value_ff   <= value_ff;
         rsp_length_ff  <= len_ff;
         rsp_removed_ff <= rem_ff;
      end
   end

   // store memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_length        = rsp_length_ff;
   assign rsp_removed_count = rsp_removed_ff;

   // checks
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CAPACITY))
      else $error("list length past capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && (mem_waddr == mem_raddr)))
      else $error("store read and write hit the same address");

   a_del_conserve: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DEL && state_in == B_DONE) |=>
         ({1'b0, len_ff} + {1'b0, rem_ff} == {1'b0, $past(len_ff)}))
      else $error("delete lost or invented entries");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DONE && out_free) |=> (rsp_valid_ff && state_ff == B_IDLE))
      else $error("finished result not presented");

endmodule

// ===== tb/sv/ordered_list_shift_store_tb.sv =====
// ordered_list_shift_store_tb: self-checking bench for the ordered list shift store.
// Drives insert, delete, read and clear words; checks each response against a local
// list model or a typed row's result. Depends on ols_pkg and ordered_list_shift_store.
`timescale 1ns / 100ps

module ordered_list_shift_store_tb
   import ols_pkg::*;
();

   localparam int CAP = CAPACITY_DEF;
   localparam int DW  = DATA_WIDTH_DEF;
   localparam int LW  = $clog2(CAPACITY_DEF + 1);

   localparam int SEGMENTS     = 11;
   localparam int SEGMENT_LEN  = 100;
   localparam int TAIL_CYCLES  = 120;
   localparam int CYCLE_LIMIT  = 800000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DW-1:0]       rd;
      logic [LW-1:0]       len;
      logic [LW-1:0]       removed;
   } list_result_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [DW-1:0]     value;
      int                reps;
      bit                typed;
      list_result_type   want;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode;
   logic [POS_W-1:0]    req_position;
   logic [DW-1:0]       req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [DW-1:0]       rsp_read_value;
   logic [LW-1:0]       rsp_length;
   logic [LW-1:0]       rsp_removed_count;

   // local copy of the list contents
   logic [DW-1:0] list_store [CAP];
   int            list_len = 0;

   list_result_type  pending_results [$];
   stim_row_type     directed_rows [$];
   list_result_type  head_result;
   int               mismatch_count = 0;
   int               cycle_count = 0;

   ordered_list_shift_store i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_length        (rsp_length),
      .rsp_removed_count (rsp_removed_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // apply one operation to the local list and return the response it yields
   function automatic list_result_type apply_list_op(input logic [MODE_W-1:0] mode,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DW-1:0] word);
      list_result_type res;
      int              slot;
      int              keep;
      int              removed;
      res     = '0;
      removed = 0;
      case (mode)
         MODE_INSERT: begin
            if (list_len >= CAP) begin
               res.status = STATUS_FULL;
            end else begin
               slot = (int'(pos) > list_len) ? list_len : int'(pos);
               for (int i = list_len; i > slot; i--)
                  list_store[i] = list_store[i-1];
               list_store[slot] = word;
               list_len++;
            end
         end
         MODE_DELETE: begin
            // drop every match, close up the rest in order
            keep = 0;
            for (int i = 0; i < list_len; i++) begin
               if (list_store[i] == word) begin
                  removed++;
               end else begin
                  list_store[keep] = list_store[i];
                  keep++;
               end
            end
            list_len = keep;
         end
         MODE_READ: begin
            if (int'(pos) < list_len)
               res.rd = list_store[pos];
            else
               res.status = STATUS_RANGE;
         end
         default: begin
            list_len = 0;
         end
      endcase
      res.len     = LW'(list_len);
      res.removed = LW'(removed);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [DW-1:0] got,
                                  input logic [DW-1:0] want);
      $display("%0t: %s got %h want %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic add_row(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                          input logic [DW-1:0] value, input int reps, input bit typed,
                          input logic [STATUS_W-1:0] status, input logic [DW-1:0] rd,
                          input int len, input int removed);
      stim_row_type row;
      row.mode         = mode;
      row.pos          = pos;
      row.value        = value;
      row.reps         = reps;
      row.typed        = typed;
      row.want.status  = status;
      row.want.rd      = rd;
      row.want.len     = LW'(len);
      row.want.removed = LW'(removed);
      directed_rows.push_back(row);
   endtask

   // present one word and hold it until taken; the expectation is queued on acceptance
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                            input logic [DW-1:0] word, input bit typed,
                            input list_result_type want);
      list_result_type predicted;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= word;
      do @(posedge clock); while (req_stall);
      predicted = apply_list_op(mode, pos, word);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // mostly back to back, sometimes short, rarely long; always back to back when calm
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 19);
      if (calm || r < 12)
         return 0;
      else if (r < 18)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 25);
   endfunction

   // response side back-pressure: short stalls, the odd long one, some free stretches
   initial begin
      int pick;
      int free_run;
      int stall_run;
      rsp_stall = 1'b0;
      forever begin
         pick      = $urandom_range(0, 19);
         free_run  = (pick < 3) ? $urandom_range(20, 60) : $urandom_range(1, 3);
         stall_run = (pick == 19) ? $urandom_range(8, 30) :
                     (pick >= 12) ? $urandom_range(1, 3) : 0;
         repeat (free_run) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (stall_run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   // compare each taken response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending, length", DW'(rsp_length), '0);
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_status !== head_result.status)
               report_mismatch("status", DW'(rsp_status), DW'(head_result.status));
            if (rsp_read_value !== head_result.rd)
               report_mismatch("read_value", rsp_read_value, head_result.rd);
            if (rsp_length !== head_result.len)
               report_mismatch("length", DW'(rsp_length), DW'(head_result.len));
            if (rsp_removed_count !== head_result.removed)
               report_mismatch("removed_count", DW'(rsp_removed_count),
                               DW'(head_result.removed));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [DW-1:0]     word_pool [8];
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [DW-1:0]     word;
      int                ins_weight;
      int                rest;
      int                r;
      bit                calm;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_INSERT;
      req_position = '0;
      req_value    = '0;

      // directed rows: empty list, extremes, shifting inserts, full list, delete all
      add_row(MODE_READ,   6'd0,  32'h0000_0000, 1,  1'b1, STATUS_RANGE, 32'h0, 0, 0);
      add_row(MODE_DELETE, 6'd0,  32'h0000_0000, 1,  1'b1, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_CLEAR,  6'd63, 32'hFFFF_FFFF, 1,  1'b1, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_INSERT, 6'd63, 32'h7FFF_FFFF, 1,  1'b1, STATUS_OK, 32'h0, 1, 0);
      add_row(MODE_INSERT, 6'd0,  32'h8000_0000, 1,  1'b1, STATUS_OK, 32'h0, 2, 0);
      add_row(MODE_INSERT, 6'd1,  32'h0000_0000, 1,  1'b1, STATUS_OK, 32'h0, 3, 0);
      add_row(MODE_INSERT, 6'd1,  32'hFFFF_FFFF, 1,  1'b1, STATUS_OK, 32'h0, 4, 0);
      add_row(MODE_READ,   6'd0,  32'h0000_0000, 1,  1'b1, STATUS_OK, 32'h8000_0000, 4, 0);
      add_row(MODE_READ,   6'd3,  32'h0000_0000, 1,  1'b1, STATUS_OK, 32'h7FFF_FFFF, 4, 0);
      add_row(MODE_READ,   6'd4,  32'h0000_0000, 1,  1'b1, STATUS_RANGE, 32'h0, 4, 0);
      add_row(MODE_READ,   6'd63, 32'h0000_0000, 1,  1'b1, STATUS_RANGE, 32'h0, 4, 0);
      add_row(MODE_INSERT, 6'd2,  32'hFFFF_FFFF, 1,  1'b0, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_READ,   6'd1,  32'h0000_0000, 1,  1'b0, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_DELETE, 6'd0,  32'hFFFF_FFFF, 1,  1'b1, STATUS_OK, 32'h0, 3, 2);
      add_row(MODE_DELETE, 6'd5,  32'h1234_5678, 1,  1'b1, STATUS_OK, 32'h0, 3, 0);
      add_row(MODE_READ,   6'd2,  32'h0000_0000, 1,  1'b0, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_INSERT, 6'd3,  32'h0000_002A, 1,  1'b0, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_CLEAR,  6'd0,  32'h0000_0000, 1,  1'b1, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_INSERT, 6'd0,  32'h0000_00A5, CAP, 1'b0, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_INSERT, 6'd10, 32'h0000_0001, 1,  1'b1, STATUS_FULL, 32'h0, CAP, 0);
      add_row(MODE_READ,   6'd63, 32'h0000_0000, 1,  1'b1, STATUS_OK, 32'h0000_00A5, CAP, 0);
      add_row(MODE_READ,   6'd0,  32'h0000_0000, 1,  1'b0, STATUS_OK, 32'h0, 0, 0);
      add_row(MODE_DELETE, 6'd0,  32'h0000_00A5, 1,  1'b1, STATUS_OK, 32'h0, 0, CAP);
      add_row(MODE_READ,   6'd0,  32'h0000_0000, 1,  1'b1, STATUS_RANGE, 32'h0, 0, 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            send_word(directed_rows[i].mode, directed_rows[i].pos, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
            hold_off(pick_gap(1'b0));
         end
      end

      // random segments, each with its own insert bias, value pool and pacing
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         r          = $urandom_range(0, 2);
         ins_weight = (r == 0) ? 35 : (r == 1) ? 55 : 80;
         rest       = 99 - ins_weight;
         calm       = ($urandom_range(0, 3) == 0);
         foreach (word_pool[k])
            word_pool[k] = $urandom;
         repeat (SEGMENT_LEN) begin
            r = $urandom_range(0, 99);
            // a small pool of values makes deletes hit several entries
            word = ($urandom_range(0, 9) < 6) ? word_pool[$urandom_range(0, 7)] : $urandom;
            pos  = POS_W'($urandom_range(0, 63));
            if (r < ins_weight) begin
               mode = MODE_INSERT;
               if ($urandom_range(0, 1) == 0)
                  pos = (list_len > 63) ? 6'd63 : POS_W'($urandom_range(0, list_len));
            end else if (r == 99) begin
               mode = MODE_CLEAR;
            end else if (r < ins_weight + (rest * 3) / 5) begin
               mode = MODE_READ;
               if (list_len > 0 && $urandom_range(0, 3) != 0)
                  pos = POS_W'($urandom_range(0, list_len - 1));
            end else begin
               mode = MODE_DELETE;
               if (list_len > 0 && $urandom_range(0, 3) != 0)
                  word = list_store[$urandom_range(0, list_len - 1)];
            end
            send_word(mode, pos, word, 1'b0, '0);
            hold_off(pick_gap(calm));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then let a worst-case delete finish before judging
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
